FILE: src/jdz_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jdz_pkg;

   // Field and datapath widths.
   localparam int DZ_W     = 15;
   localparam int RAW_W    = 16;
   localparam int DATA_W   = 32;
   localparam int USER_W   = 2;
   localparam int CSR_IX_W = 1;
   localparam int MAG_W    = 17;
   localparam int L2_W     = 32;
   localparam int ROOT_W   = 24;
   localparam int Q_W      = 16;
   localparam int DIFF_W   = 24;
   localparam int DEN_W    = 23;
   localparam int PROD_W   = 39;
   localparam int N1_W     = 41;
   localparam int D1_W     = 24;
   localparam int PX_W     = 32;
   localparam int N2_W     = 42;
   localparam int D2_W     = 25;

   localparam logic [DZ_W-1:0] FULL_SCALE    = 15'd32767;
   localparam logic [DZ_W-1:0] STICK_DZ_INIT = 15'd4915;
   localparam logic [DZ_W-1:0] TRIG_DZ_INIT  = 15'd1638;

   // Mode codes carried in tuser.
   localparam logic [1:0] MODE_AXIAL   = 2'd0;
   localparam logic [1:0] MODE_TRIGGER = 2'd1;
   localparam logic [1:0] MODE_RADIAL  = 2'd2;

   // Register indexes of the control port.
   localparam logic [CSR_IX_W-1:0] CSR_STICK_DZ = 1'd0;
   localparam logic [CSR_IX_W-1:0] CSR_TRIG_DZ  = 1'd1;

   // Per-sample context from the front stages into the square root.
   typedef struct packed {
      logic [1:0]       mode;
      logic             x_neg;
      logic             y_neg;
      logic [MAG_W-1:0] ax;
      logic [MAG_W-1:0] ay;
      logic [DZ_W-1:0]  m;
      logic             lt;
      logic             zr;
   } ctx_type;

   // Context that rides through the first divider.
   typedef struct packed {
      ctx_type           ctx;
      logic [ROOT_W-1:0] m8;
   } mid_type;

   // Context that rides through the x component divider.
   typedef struct packed {
      logic [1:0]      mode;
      logic            x_neg;
      logic            lt;
      logic            zr;
      logic [DZ_W-1:0] sq;
   } tail_type;

endpackage

`default_nettype wire

FILE: src/jdz_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined integer square root of (l2 << 16), one root bit per stage.
module jdz_sqrt #(
   parameter int SW = 1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       en,
   input  wire logic                       in_valid,
   input  wire logic [jdz_pkg::L2_W-1:0]   in_l2,
   input  wire logic [SW-1:0]              in_sb,
   output logic                            out_valid,
   output logic [jdz_pkg::ROOT_W-1:0]      out_root,
   output logic [SW-1:0]                   out_sb
);
   import jdz_pkg::*;

   localparam int STEPS = ROOT_W;
   localparam int V_W   = 2 * ROOT_W;
   localparam int RW    = ROOT_W + 3;

   logic [V_W-1:0]    s_v    [STEPS+1];
   logic [RW-1:0]     s_rem  [STEPS+1];
   logic [ROOT_W-1:0] s_root [STEPS+1];
   logic [SW-1:0]     s_sb   [STEPS+1];
   logic              s_vld  [STEPS+1];

   // The radicand is the squared length scaled up by 2^16.
   assign s_v[0]    = {in_l2, {(V_W-L2_W){1'b0}}};
   assign s_rem[0]  = '0;
   assign s_root[0] = '0;
   assign s_sb[0]   = in_sb;
   assign s_vld[0]  = in_valid;

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic [V_W-1:0]    v_ff;
      logic [RW-1:0]     rem_ff;
      logic [ROOT_W-1:0] root_ff;
      logic [SW-1:0]     sb_ff;
      logic              vld_ff;
      logic [RW-1:0]     rem_sh;
      logic [RW-1:0]     trial;
      logic              take;

      // Bring down the next two radicand bits and try the next root bit.
      assign rem_sh = {s_rem[i][RW-3:0], s_v[i][V_W-1 -: 2]};
      assign trial  = {1'b0, s_root[i], 2'b01};
      assign take   = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= s_vld[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= take ? (rem_sh - trial) : rem_sh;
            root_ff <= {s_root[i][ROOT_W-2:0], take};
            v_ff    <= {s_v[i][V_W-3:0], 2'b00};
            sb_ff   <= s_sb[i];
         end
      end

      assign s_v[i+1]    = v_ff;
      assign s_rem[i+1]  = rem_ff;
      assign s_root[i+1] = root_ff;
      assign s_sb[i+1]   = sb_ff;
      assign s_vld[i+1]  = vld_ff;
   end

   assign out_valid = s_vld[STEPS];
   assign out_root  = s_root[STEPS];
   assign out_sb    = s_sb[STEPS];

endmodule

`default_nettype wire

FILE: src/jdz_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider with a 16-bit quotient. The first stage flags
// quotients that do not fit, then one quotient bit is resolved per stage.
module jdz_div #(
   parameter int NW = 41,
   parameter int DW = 24,
   parameter int SW = 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire logic                    in_valid,
   input  wire logic [NW-1:0]           in_n,
   input  wire logic [DW-1:0]           in_d,
   input  wire logic [SW-1:0]           in_sb,
   output logic                         out_valid,
   output logic [jdz_pkg::Q_W-1:0]      out_q,
   output logic                         out_sat,
   output logic [SW-1:0]                out_sb
);
   import jdz_pkg::*;

   logic [NW-1:0]  s_rem [Q_W+1];
   logic [DW-1:0]  s_d   [Q_W+1];
   logic [Q_W-1:0] s_q   [Q_W+1];
   logic           s_sat [Q_W+1];
   logic [SW-1:0]  s_sb  [Q_W+1];
   logic           s_vld [Q_W+1];

   logic [NW-1:0]  rem0_ff;
   logic [DW-1:0]  d0_ff;
   logic           sat0_ff;
   logic [SW-1:0]  sb0_ff;
   logic           vld0_ff;

   // Overflow check: the quotient needs more than Q_W bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else if (en) begin
         vld0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem0_ff <= in_n;
         d0_ff   <= in_d;
         sat0_ff <= (in_n >= (NW'(in_d) << Q_W));
         sb0_ff  <= in_sb;
      end
   end

   assign s_rem[0] = rem0_ff;
   assign s_d[0]   = d0_ff;
   assign s_q[0]   = '0;
   assign s_sat[0] = sat0_ff;
   assign s_sb[0]  = sb0_ff;
   assign s_vld[0] = vld0_ff;

   for (genvar j = 0; j < Q_W; j++) begin : g_bit
      localparam int K = Q_W - 1 - j;
      logic [NW-1:0]  rem_ff;
      logic [DW-1:0]  d_ff;
      logic [Q_W-1:0] q_ff;
      logic           sat_ff;
      logic [SW-1:0]  sb_ff;
      logic           vld_ff;
      logic [NW-1:0]  trial;
      logic           take;

      // Subtract the divisor shifted to this quotient bit when it fits.
      assign trial = NW'(s_d[j]) << K;
      assign take  = (s_rem[j] >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= s_vld[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff <= take ? (s_rem[j] - trial) : s_rem[j];
            d_ff   <= s_d[j];
            q_ff   <= {s_q[j][Q_W-2:0], take};
            sat_ff <= s_sat[j];
            sb_ff  <= s_sb[j];
         end
      end

      assign s_rem[j+1] = rem_ff;
      assign s_d[j+1]   = d_ff;
      assign s_q[j+1]   = q_ff;
      assign s_sat[j+1] = sat_ff;
      assign s_sb[j+1]  = sb_ff;
      assign s_vld[j+1] = vld_ff;
   end

   assign out_valid = s_vld[Q_W];
   assign out_q     = s_q[Q_W];
   assign out_sat   = s_sat[Q_W];
   assign out_sb    = s_sb[Q_W];

endmodule

`default_nettype wire

FILE: src/joystick_deadzone_conditioner.sv
`timescale 1ns / 1ps
`default_nettype none

// Joystick dead-zone conditioner. Each transfer on the req side carries a
// mode (axial stick axis, trigger, or radial stick pair) and raw readings,
// and produces one conditioned result on the rsp side, full scale 32767.
// The datapath is a fully pipelined chain: four front stages, a 24-stage
// square root, three stages of operand setup, a 17-stage divider for the
// rescale factor, three more setup stages, a second pair of 17-stage
// dividers for the radial components, a final stage and the output
// register. One sample is accepted every cycle while the skid register at
// the output is empty; that register catches the next result while a
// result waits to be taken, and the whole pipeline holds while it is full.
// Dead-zone registers are written through the csr port and must only
// change while no sample is in flight.
module joystick_deadzone_conditioner (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // req_tdata: x_raw [15:0], y_raw [31:16]
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [jdz_pkg::DATA_W-1:0]    req_tdata,
   // req_tuser: mode [1:0]
   input  wire logic [jdz_pkg::USER_W-1:0]    req_tuser,
   // rsp_tdata: x_out [15:0], y_out [31:16]
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [jdz_pkg::DATA_W-1:0]         rsp_tdata,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [jdz_pkg::CSR_IX_W-1:0]  csr_index,
   input  wire logic [jdz_pkg::DZ_W-1:0]      csr_data
);
   import jdz_pkg::*;

   function automatic logic [RAW_W-1:0] apply_sign(input logic neg,
                                                   input logic [DZ_W-1:0] mag);
      logic [RAW_W-1:0] w;
      w = {1'b0, mag};
      return neg ? (RAW_W'(0) - w) : w;
   endfunction

   // Dead-zone registers.
   logic [DZ_W-1:0] stick_dz_ff;
   logic [DZ_W-1:0] trig_dz_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stick_dz_ff <= STICK_DZ_INIT;
         trig_dz_ff  <= TRIG_DZ_INIT;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_STICK_DZ: stick_dz_ff <= csr_data;
            CSR_TRIG_DZ:  trig_dz_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // The whole pipeline advances while the skid register is empty.
   logic skid_v_ff;
   logic en;

   assign en         = ~skid_v_ff;
   assign req_tready = en;

   // Stage 0: capture the transfer.
   logic             v0_ff;
   logic [1:0]       mode0_ff;
   logic [RAW_W-1:0] x0_ff;
   logic [RAW_W-1:0] y0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode0_ff <= req_tuser;
         x0_ff    <= req_tdata[RAW_W-1:0];
         y0_ff    <= req_tdata[DATA_W-1:RAW_W];
      end
   end

   // Stage 1: magnitudes, clamped axis magnitude and dead-zone test.
   logic [MAG_W-1:0] ax1;
   logic [MAG_W-1:0] ay1;
   logic [DZ_W-1:0]  m1;
   logic [DZ_W-1:0]  da1;
   ctx_type          ctx1_in;
   ctx_type          ctx1_ff;
   logic             v1_ff;

   always_comb begin
      ax1 = x0_ff[RAW_W-1] ? (MAG_W'(0) - {1'b1, x0_ff}) : {1'b0, x0_ff};
      ay1 = y0_ff[RAW_W-1] ? (MAG_W'(0) - {1'b1, y0_ff}) : {1'b0, y0_ff};
      m1  = (ax1 > MAG_W'(FULL_SCALE)) ? FULL_SCALE : ax1[DZ_W-1:0];
      da1 = (mode0_ff == MODE_TRIGGER) ? trig_dz_ff : stick_dz_ff;
      ctx1_in.mode  = mode0_ff;
      ctx1_in.x_neg = x0_ff[RAW_W-1];
      ctx1_in.y_neg = y0_ff[RAW_W-1];
      ctx1_in.ax    = ax1;
      ctx1_in.ay    = ay1;
      ctx1_in.m     = m1;
      ctx1_in.lt    = (m1 < da1);
      ctx1_in.zr    = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx1_ff <= ctx1_in;
      end
   end

   // Stage 2: squares of the components and of the dead zone.
   logic [L2_W-1:0] axw2;
   logic [L2_W-1:0] ayw2;
   logic [L2_W-1:0] dw2;
   logic [L2_W-1:0] xx2_ff;
   logic [L2_W-1:0] yy2_ff;
   logic [L2_W-1:0] dd2_ff;
   ctx_type         ctx2_ff;
   logic            v2_ff;

   assign axw2 = L2_W'(ctx1_ff.ax);
   assign ayw2 = L2_W'(ctx1_ff.ay);
   assign dw2  = L2_W'(stick_dz_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xx2_ff  <= axw2 * axw2;
         yy2_ff  <= ayw2 * ayw2;
         dd2_ff  <= dw2 * dw2;
         ctx2_ff <= ctx1_ff;
      end
   end

   // Stage 3: squared length and the radial dead-zone test.
   logic [L2_W-1:0] l2_3;
   ctx_type         ctx3_in;
   logic [L2_W-1:0] l2_3_ff;
   ctx_type         ctx3_ff;
   logic            v3_ff;

   always_comb begin
      l2_3       = xx2_ff + yy2_ff;
      ctx3_in    = ctx2_ff;
      ctx3_in.zr = (l2_3 < dd2_ff) || (l2_3 == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l2_3_ff <= l2_3;
         ctx3_ff <= ctx3_in;
      end
   end

   // Length in units of 1/256 LSB.
   logic                       sq_v;
   logic [ROOT_W-1:0]          sq_root;
   logic [$bits(ctx_type)-1:0] sq_sb;

   jdz_sqrt #(
      .SW ($bits(ctx_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_l2     (l2_3_ff),
      .in_sb     (ctx3_ff),
      .out_valid (sq_v),
      .out_root  (sq_root),
      .out_sb    (sq_sb)
   );

   // Stage P1: live-range numerator and denominator for either path.
   ctx_type           ctx4;
   logic [DZ_W-1:0]   da4;
   logic [DIFF_W-1:0] diff4;
   logic [DEN_W-1:0]  den4;
   logic [DIFF_W-1:0] diff_p1_ff;
   logic [DEN_W-1:0]  den_p1_ff;
   mid_type           mid_p1_ff;
   logic              v_p1_ff;

   always_comb begin
      ctx4 = ctx_type'(sq_sb);
      da4  = (ctx4.mode == MODE_TRIGGER) ? trig_dz_ff : stick_dz_ff;
      if (ctx4.mode == MODE_RADIAL) begin
         diff4 = sq_root - DIFF_W'({stick_dz_ff, 8'b0});
         den4  = {FULL_SCALE - stick_dz_ff, 8'b0};
      end else begin
         diff4 = ctx4.lt ? '0 : DIFF_W'(ctx4.m - da4);
         den4  = DEN_W'(FULL_SCALE - da4);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_p1_ff <= 1'b0;
      end else if (en) begin
         v_p1_ff <= sq_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff_p1_ff    <= diff4;
         den_p1_ff     <= den4;
         mid_p1_ff.ctx <= ctx4;
         mid_p1_ff.m8  <= sq_root;
      end
   end

   // Stage P2: times full scale, as a shift and subtract.
   logic [PROD_W-1:0] prod_p2_ff;
   logic [DEN_W-1:0]  den_p2_ff;
   mid_type           mid_p2_ff;
   logic              v_p2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_p2_ff <= 1'b0;
      end else if (en) begin
         v_p2_ff <= v_p1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_p2_ff <= (PROD_W'(diff_p1_ff) << DZ_W) - PROD_W'(diff_p1_ff);
         den_p2_ff  <= den_p1_ff;
         mid_p2_ff  <= mid_p1_ff;
      end
   end

   // Stage P3: dividend and divisor with round-half-up folded in.
   logic [N1_W-1:0] n1_p3_ff;
   logic [D1_W-1:0] d1_p3_ff;
   mid_type         mid_p3_ff;
   logic            v_p3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_p3_ff <= 1'b0;
      end else if (en) begin
         v_p3_ff <= v_p2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n1_p3_ff  <= (N1_W'(prod_p2_ff) << 1) + N1_W'(den_p2_ff);
         d1_p3_ff  <= {den_p2_ff, 1'b0};
         mid_p3_ff <= mid_p2_ff;
      end
   end

   // Rescale factor, or the axial magnitude.
   logic                       dv1_v;
   logic [Q_W-1:0]             dv1_q;
   logic                       dv1_sat;
   logic [$bits(mid_type)-1:0] dv1_sb;

   jdz_div #(
      .NW (N1_W),
      .DW (D1_W),
      .SW ($bits(mid_type))
   ) u_div_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v_p3_ff),
      .in_n      (n1_p3_ff),
      .in_d      (d1_p3_ff),
      .in_sb     (mid_p3_ff),
      .out_valid (dv1_v),
      .out_q     (dv1_q),
      .out_sat   (dv1_sat),
      .out_sb    (dv1_sb)
   );

   // Stage R1: saturate the factor.
   mid_type           mid5;
   tail_type          tail_r1_ff;
   logic [MAG_W-1:0]  ax_r1_ff;
   logic [MAG_W-1:0]  ay_r1_ff;
   logic              yneg_r1_ff;
   logic [ROOT_W-1:0] m8_r1_ff;
   logic              v_r1_ff;

   assign mid5 = mid_type'(dv1_sb);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_r1_ff <= 1'b0;
      end else if (en) begin
         v_r1_ff <= dv1_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tail_r1_ff.mode  <= mid5.ctx.mode;
         tail_r1_ff.x_neg <= mid5.ctx.x_neg;
         tail_r1_ff.lt    <= mid5.ctx.lt;
         tail_r1_ff.zr    <= mid5.ctx.zr;
         tail_r1_ff.sq    <= (dv1_sat || dv1_q[Q_W-1]) ? FULL_SCALE : dv1_q[DZ_W-1:0];
         ax_r1_ff         <= mid5.ctx.ax;
         ay_r1_ff         <= mid5.ctx.ay;
         yneg_r1_ff       <= mid5.ctx.y_neg;
         m8_r1_ff         <= mid5.m8;
      end
   end

   // Stage R2: component times factor.
   logic [PX_W-1:0]   px_r2_ff;
   logic [PX_W-1:0]   py_r2_ff;
   tail_type          tail_r2_ff;
   logic              yneg_r2_ff;
   logic [ROOT_W-1:0] m8_r2_ff;
   logic              v_r2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_r2_ff <= 1'b0;
      end else if (en) begin
         v_r2_ff <= v_r1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_r2_ff   <= PX_W'(ax_r1_ff) * PX_W'(tail_r1_ff.sq);
         py_r2_ff   <= PX_W'(ay_r1_ff) * PX_W'(tail_r1_ff.sq);
         tail_r2_ff <= tail_r1_ff;
         yneg_r2_ff <= yneg_r1_ff;
         m8_r2_ff   <= m8_r1_ff;
      end
   end

   // Stage R3: component dividends and the shared divisor.
   logic [N2_W-1:0] nx_r3_ff;
   logic [N2_W-1:0] ny_r3_ff;
   logic [D2_W-1:0] d2_r3_ff;
   tail_type        tail_r3_ff;
   logic            yneg_r3_ff;
   logic            v_r3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_r3_ff <= 1'b0;
      end else if (en) begin
         v_r3_ff <= v_r2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nx_r3_ff   <= (N2_W'(px_r2_ff) << 9) + N2_W'(m8_r2_ff);
         ny_r3_ff   <= (N2_W'(py_r2_ff) << 9) + N2_W'(m8_r2_ff);
         d2_r3_ff   <= {m8_r2_ff, 1'b0};
         tail_r3_ff <= tail_r2_ff;
         yneg_r3_ff <= yneg_r2_ff;
      end
   end

   // Radial components, x and y side by side.
   logic                        dx_v;
   logic [Q_W-1:0]              dx_q;
   logic                        dx_sat;
   logic [$bits(tail_type)-1:0] dx_sb;
   logic                        dy_v;
   logic [Q_W-1:0]              dy_q;
   logic                        dy_sat;
   logic                        dy_sb;

   jdz_div #(
      .NW (N2_W),
      .DW (D2_W),
      .SW ($bits(tail_type))
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v_r3_ff),
      .in_n      (nx_r3_ff),
      .in_d      (d2_r3_ff),
      .in_sb     (tail_r3_ff),
      .out_valid (dx_v),
      .out_q     (dx_q),
      .out_sat   (dx_sat),
      .out_sb    (dx_sb)
   );

   jdz_div #(
      .NW (N2_W),
      .DW (D2_W),
      .SW (1)
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v_r3_ff),
      .in_n      (ny_r3_ff),
      .in_d      (d2_r3_ff),
      .in_sb     (yneg_r3_ff),
      .out_valid (dy_v),
      .out_q     (dy_q),
      .out_sat   (dy_sat),
      .out_sb    (dy_sb)
   );

   // Final stage: saturate, apply signs and select by mode.
   tail_type         tail6;
   logic [DZ_W-1:0]  qx_mag;
   logic [DZ_W-1:0]  qy_mag;
   logic [RAW_W-1:0] xo6;
   logic [RAW_W-1:0] yo6;
   logic             pf_v_ff;
   logic [RAW_W-1:0] pf_x_ff;
   logic [RAW_W-1:0] pf_y_ff;

   always_comb begin
      tail6  = tail_type'(dx_sb);
      qx_mag = (dx_sat || dx_q[Q_W-1]) ? FULL_SCALE : dx_q[DZ_W-1:0];
      qy_mag = (dy_sat || dy_q[Q_W-1]) ? FULL_SCALE : dy_q[DZ_W-1:0];
      xo6    = '0;
      yo6    = '0;
      case (tail6.mode)
         MODE_AXIAL: begin
            if (!tail6.lt) begin
               xo6 = apply_sign(tail6.x_neg, tail6.sq);
            end
         end
         MODE_TRIGGER: begin
            if (!tail6.lt && !tail6.x_neg) begin
               xo6 = {1'b0, tail6.sq};
            end
         end
         MODE_RADIAL: begin
            if (!tail6.zr) begin
               xo6 = apply_sign(tail6.x_neg, qx_mag);
               yo6 = apply_sign(dy_sb, qy_mag);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pf_v_ff <= 1'b0;
      end else if (en) begin
         pf_v_ff <= dx_v & dy_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pf_x_ff <= xo6;
         pf_y_ff <= yo6;
      end
   end

   // Output register with a skid register behind it.
   logic              out_v_ff;
   logic [DATA_W-1:0] out_data_ff;
   logic [DATA_W-1:0] skid_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_tready) begin
         out_v_ff  <= skid_v_ff | pf_v_ff;
         skid_v_ff <= 1'b0;
      end else if (en && pf_v_ff) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_tready) begin
         out_data_ff <= skid_v_ff ? skid_data_ff : {pf_y_ff, pf_x_ff};
      end else if (en) begin
         skid_data_ff <= {pf_y_ff, pf_x_ff};
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

FILE: src/jdz_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks for the conditioner.
module jdz_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_tready,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [jdz_pkg::DATA_W-1:0] rsp_tdata
);

   // A result that is not taken stays offered.
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // A result that is not taken keeps its data.
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp_tdata changed while stalled");

   // Outputs are saturated to the symmetric full-scale range.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:0] != 16'h8000) && (rsp_tdata[31:16] != 16'h8000))
      else $error("output outside full-scale range");

   // Reset empties the output side.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // Reset empties the skid register, so input is accepted right away.
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("not ready right after reset");

endmodule

bind joystick_deadzone_conditioner jdz_checker u_jdz_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import jdz_pkg::*;

   localparam int LATENCY     = 100;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      logic signed [15:0] x_out;
      logic signed [15:0] y_out;
   } cond_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [DATA_W-1:0] req_tdata = '0;
   logic [USER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IX_W-1:0] csr_index = '0;
   logic [DZ_W-1:0] csr_data = '0;

   // Dead-zone settings as the block should hold them.
   logic [DZ_W-1:0] stick_dz;
   logic [DZ_W-1:0] trig_dz;

   cond_type pending_results[$];
   int error_count = 0;
   int cycle_count = 0;
   int hold_off_cycles = 0;
   bit stall_free = 1'b0;

   joystick_deadzone_conditioner dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Integer square root, floor.
   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bit_val;
      root = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > v) bit_val >>= 2;
      while (bit_val != 0) begin
         if (v >= root + bit_val) begin
            v -= root + bit_val;
            root = (root >> 1) + bit_val;
         end else begin
            root >>= 1;
         end
         bit_val >>= 2;
      end
      return root;
   endfunction

   // Dead-zone rescale of one axis reading.
   function automatic int rescale_axis(int raw, int dz);
      longint unsigned mag;
      longint unsigned num;
      longint unsigned den;
      longint unsigned q;
      mag = (raw < 0) ? -raw : raw;
      if (mag > 32767) mag = 32767;
      if (mag < dz) return 0;
      if (dz >= 32767) begin
         q = 32767;
      end else begin
         num = (mag - dz) * 32767;
         den = 32767 - dz;
         q = (2 * num + den) / (2 * den);
         if (q > 32767) q = 32767;
      end
      return (raw < 0) ? -int'(q) : int'(q);
   endfunction

   // One radial component: direction times scaled length.
   function automatic int radial_component(int v, longint unsigned s,
                                           longint unsigned m8);
      longint unsigned a;
      longint unsigned q;
      a = (v < 0) ? -v : v;
      q = (2 * (a * s * 256) + m8) / (2 * m8);
      if (q > 32767) q = 32767;
      return (v < 0) ? -int'(q) : int'(q);
   endfunction

   function automatic cond_type condition_sample(logic [1:0] mode, int x, int y);
      cond_type r;
      int xo;
      longint unsigned d;
      longint unsigned l2;
      longint unsigned m8;
      longint unsigned s;
      longint unsigned den;
      xo = 0;
      r.x_out = 0;
      r.y_out = 0;
      if (mode == MODE_AXIAL) begin
         r.x_out = 16'(rescale_axis(x, stick_dz));
      end else if (mode == MODE_TRIGGER) begin
         xo = rescale_axis(x, trig_dz);
         r.x_out = (xo < 0) ? 16'sd0 : 16'(xo);
      end else if (mode == MODE_RADIAL) begin
         d = stick_dz;
         l2 = longint'(x) * x + longint'(y) * y;
         if (l2 >= d * d && l2 != 0) begin
            m8 = int_sqrt(l2 << 16);
            if (d >= 32767) begin
               s = 32767;
            end else begin
               den = (32767 - d) * 256;
               s = (2 * ((m8 - d * 256) * 32767) + den) / (2 * den);
               if (s > 32767) s = 32767;
            end
            r.x_out = 16'(radial_component(x, s, m8));
            r.y_out = 16'(radial_component(y, s, m8));
         end
      end
      return r;
   endfunction

   // Cycle counter and timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver: random stalls, a long hold-off when asked, or always ready in stall-free phases.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else if (stall_free) begin
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < 3) begin
         rsp_tready <= 1'b0;
         hold_off_cycles <= $urandom_range(5, 40);
      end else begin
         rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Compare each result transfer with the oldest expectation.
   always @(posedge clock) begin
      cond_type want;
      cond_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.x_out = rsp_tdata[15:0];
         got.y_out = rsp_tdata[31:16];
         if (pending_results.size() == 0) begin
            $error("unexpected result x_out=%0d y_out=%0d", got.x_out, got.y_out);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.x_out !== want.x_out) begin
               $error("x_out expected %0d actual %0d", want.x_out, got.x_out);
               error_count++;
            end
            if (got.y_out !== want.y_out) begin
               $error("y_out expected %0d actual %0d", want.y_out, got.y_out);
               error_count++;
            end
         end
      end
   end

   // Send one sample, with an optional gap before it.
   task automatic send_sample(logic [1:0] mode, logic [15:0] x, logic [15:0] y,
                              bit gaps = 1'b1);
      int gap;
      gap = 0;
      if (gaps) begin
         gap = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30)
             : ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(condition_sample(mode, $signed(x), $signed(y)));
   endtask

   task automatic end_of_burst();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      end_of_burst();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IX_W-1:0] index, logic [DZ_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (index == CSR_STICK_DZ) stick_dz = value;
      else trig_dz = value;
      @(posedge clock);
   endtask

   function automatic logic [15:0] random_raw();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(0, 8) - 4);
         3: return 16'($signed(stick_dz) + $urandom_range(0, 4) - 2);
         4: return -16'($signed(stick_dz) + $urandom_range(0, 4) - 2);
         default: return 16'($urandom);
      endcase
   endfunction

   // Extremes, every mode, the unused mode and the zero vector.
   task automatic test_directed();
      send_sample(MODE_AXIAL, 16'h7FFF, 16'h0000);
      send_sample(MODE_AXIAL, 16'h8000, 16'h7FFF);
      send_sample(MODE_AXIAL, 16'd4915, 16'h0000);
      send_sample(MODE_AXIAL, 16'd4914, 16'h0000);
      send_sample(MODE_AXIAL, -16'd4915, 16'hFFFF);
      send_sample(MODE_TRIGGER, 16'h7FFF, 16'h0000);
      send_sample(MODE_TRIGGER, 16'h8000, 16'h0000);
      send_sample(MODE_TRIGGER, 16'd1638, 16'h0000);
      send_sample(MODE_TRIGGER, 16'd1637, 16'h5555);
      send_sample(MODE_RADIAL, 16'h7FFF, 16'h7FFF);
      send_sample(MODE_RADIAL, 16'h8000, 16'h8000);
      send_sample(MODE_RADIAL, 16'h8000, 16'h0000);
      send_sample(MODE_RADIAL, 16'h0000, 16'h7FFF);
      send_sample(MODE_RADIAL, 16'd3000, 16'd4000);
      send_sample(MODE_RADIAL, 16'd100, -16'd100);
      send_sample(MODE_RADIAL, 16'h0000, 16'h0000);
      send_sample(2'd3, 16'h7FFF, 16'h8000);
      send_sample(2'd3, 16'hAAAA, 16'h5555);
      drain();
   endtask

   // Full dead zones and zero dead zones, including the zero vector.
   task automatic test_deadzone_extremes();
      write_csr(CSR_STICK_DZ, 15'd32767);
      write_csr(CSR_TRIG_DZ, 15'd32767);
      send_sample(MODE_AXIAL, 16'h7FFF, 16'h0000);
      send_sample(MODE_AXIAL, 16'h8000, 16'h0000);
      send_sample(MODE_AXIAL, 16'h8001, 16'h0000);
      send_sample(MODE_AXIAL, 16'h7FFE, 16'h0000);
      send_sample(MODE_TRIGGER, 16'h7FFF, 16'h0000);
      send_sample(MODE_RADIAL, 16'h7FFF, 16'h0001);
      send_sample(MODE_RADIAL, 16'h8000, 16'h8000);
      send_sample(MODE_RADIAL, 16'h4000, 16'h4000);
      drain();
      write_csr(CSR_STICK_DZ, 15'd0);
      write_csr(CSR_TRIG_DZ, 15'd0);
      send_sample(MODE_RADIAL, 16'h0000, 16'h0000);
      send_sample(MODE_RADIAL, 16'h0001, 16'h0000);
      send_sample(MODE_AXIAL, 16'h0000, 16'h0000);
      send_sample(MODE_AXIAL, 16'hFFFF, 16'h0000);
      send_sample(MODE_TRIGGER, 16'h0001, 16'h0000);
      drain();
   endtask

   // Random samples over several dead-zone settings.
   task automatic test_random();
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 5) begin
            write_csr(CSR_STICK_DZ, 15'd32766);
            write_csr(CSR_TRIG_DZ, 15'd32766);
         end else begin
            write_csr(CSR_STICK_DZ, 15'($urandom_range(0, 32767)));
            write_csr(CSR_TRIG_DZ, 15'($urandom_range(0, 32767)));
         end
         stall_free = (phase == 2);
         for (int i = 0; i < 90; i++)
            send_sample(2'($urandom_range(0, 3)), random_raw(), random_raw(),
                        phase != 2);
         drain();
      end
      stall_free = 1'b0;
   endtask

   // Receiver holds off while the sender keeps offering samples.
   task automatic test_backpressure();
      write_csr(CSR_STICK_DZ, STICK_DZ_INIT);
      write_csr(CSR_TRIG_DZ, TRIG_DZ_INIT);
      // Arm the hold-off away from the rising edge so the receiver sees it.
      @(negedge clock);
      hold_off_cycles = 300;
      @(posedge clock);
      for (int i = 0; i < 80; i++)
         send_sample(2'($urandom_range(0, 2)), 16'($urandom), 16'($urandom), 1'b0);
      drain();
   endtask

   initial begin
      stick_dz = STICK_DZ_INIT;
      trig_dz = TRIG_DZ_INIT;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_deadzone_extremes();
      test_random();
      test_backpressure();
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
